FILE: design/zwg_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the zig-zag waypoint generator.
// No dependencies; used by zwg_ctrl, zwg_datapath and the top level.
package zwg_pkg;

   localparam int MAX_BEACONS = 16;
   localparam int MAX_COLUMNS = 32;
   localparam int IDX_W = (MAX_BEACONS > 1) ? $clog2(MAX_BEACONS) : 1;
   localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

   localparam logic [4:0]  QUORUM_RESET  = 5'd3;
   localparam logic [11:0] STEP_RESET    = 12'd100;
   localparam logic [11:0] PADDING_RESET = 12'd100;

   typedef enum logic [1:0] {
      REG_BEACON_QUORUM = 2'd0,
      REG_COLUMN_STEP   = 2'd1,
      REG_EDGE_PADDING  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [7:0]         beacon_address;
      logic signed [15:0] beacon_x;
      logic signed [15:0] beacon_y;
   } req_data_type;

   typedef struct packed {
      logic signed [15:0] waypoint_x;
      logic signed [15:0] waypoint_y;
      logic [5:0]         waypoint_number;
      logic               no_path;
      logic               cut_short;
      logic               last_waypoint;
   } rsp_data_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_BOUND,
      ST_EMIT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic table_write;
      logic scan_start;
      logic scan_step;
      logic bound_load;
      logic emit_load;
   } cmd_type;

   typedef struct packed {
      logic trigger;
      logic scan_last;
      logic out_free;
      logic path_last;
   } status_type;

   function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
      logic signed [15:0] r;
      if (v > 18'sd32767) begin
         r = 16'sh7FFF;
      end else if (v < -18'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

FILE: design/zwg_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: report intake, table scan, bound setup, path emission.
// Depends on zwg_pkg; drives commands into zwg_datapath.
module zwg_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  zwg_pkg::status_type status,
   output zwg_pkg::cmd_type    cmd
);
   import zwg_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && status.trigger) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (status.scan_last) state_in = ST_BOUND;
         end
         ST_BOUND: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free && status.path_last) state_in = ST_DONE;
         end
         ST_DONE: begin
            state_in = ST_DONE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready       = 1'b1;
            cmd.table_write = req_valid;
            cmd.scan_start  = req_valid && status.trigger;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
         end
         ST_BOUND: begin
            cmd.bound_load = 1'b1;
         end
         ST_EMIT: begin
            cmd.emit_load = status.out_free;
         end
         ST_DONE: begin
            // accept and drop
            req_ready = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

FILE: design/zwg_datapath.sv
`timescale 1ns / 1ps
// Datapath: config registers, beacon table, min/max scan, column stepping, result register.
// Depends on zwg_pkg; commanded by zwg_ctrl.
module zwg_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [11:0]           csr_wdata,
   input  zwg_pkg::req_data_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output zwg_pkg::rsp_data_type rsp_data,
   input  zwg_pkg::cmd_type      cmd,
   output zwg_pkg::status_type   status
);
   import zwg_pkg::*;

   logic [4:0]  quorum_ff;
   logic [11:0] step_ff;
   logic [11:0] pad_ff;

   logic [MAX_BEACONS-1:0] valid_ff;
   logic [7:0]             addr_ff [MAX_BEACONS];
   logic signed [15:0]     x_ff    [MAX_BEACONS];
   logic signed [15:0]     y_ff    [MAX_BEACONS];
   logic [4:0]             known_ff;

   logic [MAX_BEACONS-1:0] hit_vec;
   logic [MAX_BEACONS-1:0] free_vec;
   logic [MAX_BEACONS-1:0] wr_vec;
   logic                   hit_any;
   logic                   free_any;
   logic                   insert;
   logic [4:0]             known_in;

   logic [IDX_W-1:0]   idx_ff;
   logic               any_ff;
   logic signed [15:0] minx_ff, maxx_ff, miny_ff, maxy_ff;

   logic signed [17:0] left_in, right_in, bottom_in, top_in;
   logic signed [18:0] diff_in;
   logic signed [17:0] left_ff;
   logic [16:0]        span_ff;
   logic signed [15:0] bottom_ff, top_ff;
   logic               empty_ff;

   logic [COL_W-1:0] col_ff;
   logic             phase_ff;
   logic [16:0]      offset_ff;
   logic [17:0]      next_off;
   logic             fits;
   logic             col_max;
   logic             final_col;
   logic signed [17:0] x_wide;

   logic         trigger;
   logic         scan_last;
   logic         out_free;
   logic         path_last;

   logic         rsp_valid_ff;
   rsp_data_type rsp_data_ff;
   rsp_data_type rsp_data_in;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         quorum_ff <= QUORUM_RESET;
         step_ff   <= STEP_RESET;
         pad_ff    <= PADDING_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_BEACON_QUORUM: quorum_ff <= csr_wdata[4:0];
            REG_COLUMN_STEP:   step_ff   <= csr_wdata;
            REG_EDGE_PADDING:  pad_ff    <= csr_wdata;
            default:           quorum_ff <= quorum_ff;
         endcase
      end
   end

   // table lookup
   always_comb begin
      hit_vec  = '0;
      free_vec = '0;
      hit_any  = 1'b0;
      free_any = 1'b0;
      for (int i = 0; i < MAX_BEACONS; i++) begin
         if (valid_ff[i]) begin
            if (!hit_any && addr_ff[i] == req_data.beacon_address) begin
               hit_vec[i] = 1'b1;
               hit_any    = 1'b1;
            end
         end else if (!free_any) begin
            free_vec[i] = 1'b1;
            free_any    = 1'b1;
         end
      end
      insert   = !hit_any && free_any;
      wr_vec   = hit_any ? hit_vec : free_vec;
      known_in = 5'(known_ff + {4'd0, insert});
      trigger  = known_in >= quorum_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         known_ff <= '0;
      end else if (cmd.table_write) begin
         valid_ff <= valid_ff | wr_vec;
         known_ff <= known_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_BEACONS; i++) begin
         if (cmd.table_write && wr_vec[i]) begin
            addr_ff[i] <= req_data.beacon_address;
            x_ff[i]    <= req_data.beacon_x;
            y_ff[i]    <= req_data.beacon_y;
         end
      end
   end

   // min/max walk
   assign scan_last = idx_ff == IDX_W'(MAX_BEACONS - 1);

   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         idx_ff <= '0;
         any_ff <= 1'b0;
      end else if (cmd.scan_step) begin
         idx_ff <= IDX_W'(idx_ff + 1'b1);
         if (valid_ff[idx_ff]) begin
            any_ff <= 1'b1;
            if (!any_ff || x_ff[idx_ff] < minx_ff) minx_ff <= x_ff[idx_ff];
            if (!any_ff || x_ff[idx_ff] > maxx_ff) maxx_ff <= x_ff[idx_ff];
            if (!any_ff || y_ff[idx_ff] < miny_ff) miny_ff <= y_ff[idx_ff];
            if (!any_ff || y_ff[idx_ff] > maxy_ff) maxy_ff <= y_ff[idx_ff];
         end
      end
   end

   // padded bounds
   always_comb begin
      left_in   = 18'(minx_ff) + $signed({6'd0, pad_ff});
      right_in  = 18'(maxx_ff) - $signed({6'd0, pad_ff});
      bottom_in = 18'(miny_ff) + $signed({6'd0, pad_ff});
      top_in    = 18'(maxy_ff) - $signed({6'd0, pad_ff});
      diff_in   = 19'(right_in) - 19'(left_in);
   end

   always_ff @(posedge clock) begin
      if (cmd.bound_load) begin
         left_ff   <= left_in;
         span_ff   <= diff_in[16:0];
         bottom_ff <= sat16(bottom_in);
         top_ff    <= sat16(top_in);
         empty_ff  <= !any_ff || diff_in[18];
      end
   end

   // column stepping
   always_comb begin
      next_off  = {1'b0, offset_ff} + {6'd0, step_ff};
      fits      = next_off <= {1'b0, span_ff};
      col_max   = col_ff == COL_W'(MAX_COLUMNS - 1);
      final_col = col_max || !fits;
      x_wide    = left_ff + $signed({1'b0, offset_ff});
      path_last = empty_ff || (phase_ff && final_col);

      rsp_data_in = '0;
      if (empty_ff) begin
         rsp_data_in.no_path       = 1'b1;
         rsp_data_in.last_waypoint = 1'b1;
      end else begin
         rsp_data_in.waypoint_x      = x_wide[15:0];
         rsp_data_in.waypoint_y      = (phase_ff ^ col_ff[0]) ? top_ff : bottom_ff;
         rsp_data_in.waypoint_number = 6'({col_ff, phase_ff});
         rsp_data_in.cut_short       = phase_ff && col_max && fits;
         rsp_data_in.last_waypoint   = phase_ff && final_col;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.bound_load) begin
         col_ff    <= '0;
         phase_ff  <= 1'b0;
         offset_ff <= '0;
      end else if (cmd.emit_load) begin
         if (!phase_ff) begin
            phase_ff <= 1'b1;
         end else if (!final_col) begin
            phase_ff  <= 1'b0;
            col_ff    <= COL_W'(col_ff + 1'b1);
            offset_ff <= next_off[16:0];
         end
      end
   end

   // result register
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign status    = '{trigger, scan_last, out_free, path_last};
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: design/zigzag_waypoint_generator.sv
`timescale 1ns / 1ps
// Zig-zag waypoint generator: beacon table and boustrophedon path emitter.
// Depends on zwg_pkg, zwg_ctrl and zwg_datapath.
//
// Usage:
//   req_* carries beacon reports (address, x, y). A report is taken
//   whenever the block is waiting for reports; a known address updates
//   its entry, a new one takes the next free slot (dropped if the table is
//   full). When the count of distinct beacons reaches beacon_quorum, the block
//   stops taking reports, walks the 16-entry table for the x and y extremes,
//   registers the padded bounds, then loads the output register and emits
//   up to 64 waypoints on rsp_*, one per cycle while rsp_ready is high. A
//   padded x span that holds no column yields a single result with no_path
//   set. After the path, reports are accepted and dropped.
//   A stall on rsp_ready holds the result register and freezes emission.
//   csr_* writes a register (quorum at index 0, column step at index 1,
//   edge padding at index 2); write only while no path is in progress.
//   Synchronous reset clears the table, the beacon count, the path-done state
//   and restores register defaults (3, 100, 100).
module zigzag_waypoint_generator (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [11:0]           csr_wdata,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  zwg_pkg::req_data_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output zwg_pkg::rsp_data_type rsp_data
);
   import zwg_pkg::*;

   cmd_type    cmd;
   status_type status;

   zwg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   zwg_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for zigzag_waypoint_generator: beacon reports in,
// predicted zig-zag waypoints checked in order. Depends on zwg_pkg and the RTL.
module testbench;
   import zwg_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_REPORTS = 30;
   localparam int LATE_REPORTS   = 12;
   localparam int LONG_HOLD      = 300;

   typedef enum {
      LAYOUT_NORMAL,
      LAYOUT_EMPTY,
      LAYOUT_ZERO_STEP,
      LAYOUT_CAPPED,
      LAYOUT_SATURATED
   } layout_kind_type;

   class waypoint_tracker_type;
      logic [4:0]  quorum  = QUORUM_RESET;
      logic [11:0] step    = STEP_RESET;
      logic [11:0] padding = PADDING_RESET;
      bit          slot_used[MAX_BEACONS];
      logic [7:0]  slot_addr[MAX_BEACONS];
      int          slot_x[MAX_BEACONS];
      int          slot_y[MAX_BEACONS];
      int          known = 0;
      bit          done = 0;
      int          errors = 0;
      rsp_data_type pending[$];

      function void write_register(csr_index_type idx, logic [11:0] val);
         case (idx)
            REG_BEACON_QUORUM: quorum  = val[4:0];
            REG_COLUMN_STEP:   step    = val;
            REG_EDGE_PADDING:  padding = val;
            default: ;
         endcase
      endfunction

      function logic signed [15:0] clamp16(int v);
         if (v > 32767) return 16'sh7FFF;
         if (v < -32768) return 16'sh8000;
         return v[15:0];
      endfunction

      function void add_waypoint(int x, int y, int num, bit nopath, bit cut, bit last);
         rsp_data_type w;
         w.waypoint_x      = clamp16(x);
         w.waypoint_y      = clamp16(y);
         w.waypoint_number = num[5:0];
         w.no_path         = nopath;
         w.cut_short       = cut;
         w.last_waypoint   = last;
         pending = {pending, w};
      endfunction

      function void plan_path();
         int lo_x, hi_x, lo_y, hi_y;
         int left, right, bottom, top;
         int ncols, full, xc, k;
         bit any, cut;
         any = 0;
         lo_x = 0; hi_x = 0; lo_y = 0; hi_y = 0;
         for (int i = 0; i < MAX_BEACONS; i++) begin
            if (slot_used[i]) begin
               if (!any || slot_x[i] < lo_x) lo_x = slot_x[i];
               if (!any || slot_x[i] > hi_x) hi_x = slot_x[i];
               if (!any || slot_y[i] < lo_y) lo_y = slot_y[i];
               if (!any || slot_y[i] > hi_y) hi_y = slot_y[i];
               any = 1;
            end
         end
         left   = lo_x + int'(padding);
         right  = hi_x - int'(padding);
         bottom = lo_y + int'(padding);
         top    = hi_y - int'(padding);
         if (!any || left > right) begin
            add_waypoint(0, 0, 0, 1, 0, 1);
            return;
         end
         if (step == 0) begin
            ncols = MAX_COLUMNS;
            cut = 1;
         end else begin
            full = (right - left) / int'(step) + 1;
            cut = full > MAX_COLUMNS;
            ncols = cut ? MAX_COLUMNS : full;
         end
         k = 0;
         for (int c = 0; c < ncols; c++) begin
            xc = left + c * int'(step);
            add_waypoint(xc, c[0] ? top : bottom, k, 0, 0, 0);
            k++;
            add_waypoint(xc, c[0] ? bottom : top, k, 0,
                         (c + 1 == ncols) && cut, c + 1 == ncols);
            k++;
         end
      endfunction

      function void take_report(req_data_type d);
         int hit, free_slot;
         if (done) return;
         hit = -1;
         free_slot = -1;
         for (int i = 0; i < MAX_BEACONS; i++) begin
            if (slot_used[i]) begin
               if (hit < 0 && slot_addr[i] == d.beacon_address) hit = i;
            end else if (free_slot < 0) begin
               free_slot = i;
            end
         end
         if (hit >= 0) begin
            slot_x[hit] = int'($signed(d.beacon_x));
            slot_y[hit] = int'($signed(d.beacon_y));
         end else if (free_slot >= 0) begin
            slot_used[free_slot] = 1;
            slot_addr[free_slot] = d.beacon_address;
            slot_x[free_slot] = int'($signed(d.beacon_x));
            slot_y[free_slot] = int'($signed(d.beacon_y));
            known++;
         end
         if (known >= int'(quorum)) begin
            done = 1;
            plan_path();
         end
      endfunction

      function void check_waypoint(rsp_data_type got);
         rsp_data_type want;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected waypoint: x=%0d y=%0d n=%0d np=%0b cut=%0b last=%0b",
                        got.waypoint_x, got.waypoint_y, got.waypoint_number,
                        got.no_path, got.cut_short, got.last_waypoint);
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            errors++;
            if (errors <= 10) begin
               $display("waypoint mismatch: expected x=%0d y=%0d n=%0d np=%0b cut=%0b last=%0b",
                        want.waypoint_x, want.waypoint_y, want.waypoint_number,
                        want.no_path, want.cut_short, want.last_waypoint);
               $display("                   got      x=%0d y=%0d n=%0d np=%0b cut=%0b last=%0b",
                        got.waypoint_x, got.waypoint_y, got.waypoint_number,
                        got.no_path, got.cut_short, got.last_waypoint);
            end
         end
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         csr_we;
   logic [1:0]   csr_index;
   logic [11:0]  csr_wdata;
   logic         req_valid;
   logic         req_ready;
   req_data_type req_data;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_data_type rsp_data;

   waypoint_tracker_type tracker;

   zigzag_waypoint_generator i_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   function automatic int idle_cycles();
      int r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(15, 50);
   endfunction

   function automatic logic signed [15:0] random_coord();
      case ($urandom_range(0, 9))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return 16'sh0000;
         3: return 16'shFFFF;
         default: return 16'($urandom());
      endcase
   endfunction

   function automatic req_data_type random_report();
      req_data_type d;
      int i;
      i = $urandom_range(0, MAX_BEACONS - 1);
      if (tracker.slot_used[i] && $urandom_range(0, 4) != 0)
         d.beacon_address = tracker.slot_addr[i];
      else
         d.beacon_address = 8'($urandom_range(0, 255));
      d.beacon_x = random_coord();
      d.beacon_y = random_coord();
      return d;
   endfunction

   function automatic void place_beacon(input layout_kind_type kind, input int n,
                                        output logic signed [15:0] x,
                                        output logic signed [15:0] y,
                                        input bit high_side);
      case (kind)
         LAYOUT_NORMAL: begin
            x = 16'($urandom_range(0, 3000) - 1500);
            y = 16'($urandom_range(0, 4000) - 2000);
         end
         LAYOUT_EMPTY: begin
            x = 16'($urandom_range(0, 500));
            y = 16'($urandom());
         end
         LAYOUT_ZERO_STEP: begin
            x = 16'($urandom_range(0, 6000) - 3000);
            y = 16'($urandom_range(0, 6000) - 3000);
         end
         LAYOUT_CAPPED: begin
            x = 16'($urandom());
            y = 16'($urandom());
         end
         default: begin
            x = (n == 0) ? 16'sh8000 : (n == 1) ? 16'sh7FFF : 16'($urandom());
            y = high_side ? 16'(32767 - $urandom_range(0, 50))
                          : 16'(-32768 + $urandom_range(0, 50));
         end
      endcase
   endfunction

   task automatic send_report(req_data_type d);
      int gap = idle_cycles();
      repeat (gap) begin
         @(negedge clock);
         req_valid = 0;
      end
      @(negedge clock);
      req_valid = 1;
      req_data = d;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.take_report(d);
   endtask

   task automatic write_csr(csr_index_type idx, logic [11:0] val);
      @(negedge clock);
      csr_we = 1;
      csr_index = idx;
      csr_wdata = val;
      @(posedge clock);
      tracker.write_register(idx, val);
      @(negedge clock);
      csr_we = 0;
   endtask

   task automatic settle(int cycles);
      @(negedge clock);
      req_valid = 0;
      while (tracker.pending.size() != 0) @(posedge clock);
      repeat (cycles) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) tracker.check_waypoint(rsp_data);
   end

   initial begin
      int idle;
      idle = 0;
      @(negedge clock iff !reset);
      while (idle < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we)
            idle = 0;
         else
            idle++;
      end
      $display("tb: failure");
      $finish;
   end

   initial begin
      int stall_left;
      int hold_left;
      bit held_off;
      stall_left = 0;
      hold_left = 0;
      held_off = 0;
      rsp_ready = 0;
      @(negedge clock iff !reset);
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ready = 0;
            hold_left--;
         end else if (!held_off && rsp_valid) begin
            held_off = 1;
            hold_left = LONG_HOLD;
            rsp_ready = 0;
         end else if (stall_left > 0) begin
            rsp_ready = 0;
            stall_left--;
         end else begin
            rsp_ready = 1;
            if ($urandom_range(0, 3) == 0) stall_left = idle_cycles();
         end
      end
   end

   initial begin
      req_data_type d;
      req_data_type trigger;
      layout_kind_type kind;
      logic [11:0] step_val;
      logic [11:0] pad_val;
      logic [4:0] quorum_val;
      bit high_side;
      int last_slot;
      int n;

      tracker = new;
      reset = 1;
      csr_we = 0;
      csr_index = REG_BEACON_QUORUM;
      csr_wdata = '0;
      req_valid = 0;
      req_data = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // hold off the trigger while the table is exercised
      write_csr(REG_BEACON_QUORUM, 12'h01F);
      send_report(req_data_type'{8'h00, 16'sh8000, 16'sh7FFF});
      send_report(req_data_type'{8'hFF, 16'sh7FFF, 16'sh8000});
      send_report(req_data_type'{8'h00, 16'sh0000, 16'sh0000});
      send_report(req_data_type'{8'hFF, 16'shFFFF, 16'shFFFF});
      send_report(req_data_type'{8'hAA, 16'sh5555, 16'shAAAA});
      send_report(req_data_type'{8'h55, 16'shAAAA, 16'sh5555});
      for (int a = 1; a <= 12; a++)
         send_report(req_data_type'{8'(a), random_coord(), random_coord()});
      send_report(req_data_type'{8'd200, 16'sd100, 16'sd100});
      send_report(req_data_type'{8'h00, 16'sh7FFF, 16'sh8000});
      send_report(req_data_type'{8'hFF, 16'sh8000, 16'sh7FFF});

      settle(24);
      write_csr(REG_COLUMN_STEP, 12'hFFF);
      write_csr(REG_EDGE_PADDING, 12'h000);
      repeat (RANDOM_REPORTS) send_report(random_report());

      settle(24);
      write_csr(REG_BEACON_QUORUM, 12'h011);
      write_csr(REG_COLUMN_STEP, 12'h001);
      write_csr(REG_EDGE_PADDING, 12'hFFF);
      repeat (RANDOM_REPORTS) send_report(random_report());

      // refresh every entry with a chosen layout, keep one back as the trigger
      kind = layout_kind_type'($urandom_range(0, 4));
      high_side = $urandom_range(0, 1);
      case (kind)
         LAYOUT_NORMAL: begin
            step_val = 12'($urandom_range(40, 400));
            pad_val = 12'($urandom_range(0, 300));
         end
         LAYOUT_EMPTY: begin
            step_val = 12'($urandom_range(1, 4095));
            pad_val = 12'($urandom_range(300, 4095));
         end
         LAYOUT_ZERO_STEP: begin
            step_val = 12'd0;
            pad_val = 12'($urandom_range(0, 100));
         end
         LAYOUT_CAPPED: begin
            step_val = 12'($urandom_range(1, 8));
            pad_val = 12'd0;
         end
         default: begin
            step_val = 12'hFFF;
            pad_val = 12'hFFF;
         end
      endcase
      last_slot = -1;
      for (int i = 0; i < MAX_BEACONS; i++)
         if (tracker.slot_used[i]) last_slot = i;
      n = 0;
      trigger = '0;
      for (int i = 0; i < MAX_BEACONS; i++) begin
         if (tracker.slot_used[i]) begin
            d.beacon_address = tracker.slot_addr[i];
            place_beacon(kind, n, d.beacon_x, d.beacon_y, high_side);
            if (i == last_slot)
               trigger = d;
            else
               send_report(d);
            n++;
         end
      end

      settle(24);
      quorum_val = 5'($urandom_range(0, tracker.known));
      write_csr(REG_COLUMN_STEP, step_val);
      write_csr(REG_EDGE_PADDING, pad_val);
      write_csr(REG_BEACON_QUORUM, {7'd0, quorum_val});
      send_report(trigger);
      repeat (LATE_REPORTS) send_report(random_report());

      settle(40);
      if (tracker.errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
